@@ sv/ttpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle table point locator package
// Shared types, codes and sizes for the locator block.
// ----------------------------------------------------------------------------
package ttpl_pkg;

  localparam int MaxTrianglesDefault = 64;
  localparam int CoordW = 24;
  localparam int IdW = 16;
  localparam int WeightW = 17;
  localparam int ProdW = 2 * (CoordW + 1);
  localparam int AreaW = ProdW + 1;
  localparam int DivSteps = 17;

  localparam logic [1:0] ReqClear = 2'd0;
  localparam logic [1:0] ReqAdd = 2'd1;
  localparam logic [1:0] ReqQuery = 2'd2;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StFound = 2'd1;
  localparam logic [1:0] StMiss = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [IdW-1:0] vertex_a_id;
    logic [IdW-1:0] vertex_b_id;
    logic [IdW-1:0] vertex_c_id;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [IdW-1:0] hit_a_id;
    logic [IdW-1:0] hit_b_id;
    logic [IdW-1:0] hit_c_id;
    logic [WeightW-1:0] weight_a;
    logic [WeightW-1:0] weight_b;
    logic [WeightW-1:0] weight_c;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic add;
    logic rd;
    logic tri_a;
    logic tri_b;
    logic tri_c;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic empty_scan;
    logic full;
    logic last;
    logic hit;
    logic div_last;
  } sts_t;

endpackage

@@ sv/ttpl_if.sv @@
// ----------------------------------------------------------------------------
// Triangle table point locator channel
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface ttpl_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/triangle_table_point_locator_top.sv @@
// ----------------------------------------------------------------------------
// Triangle table point locator
// Stores triangles and finds the first one that contains a query point.
// ----------------------------------------------------------------------------
// Clear and add finish after a decode step. A query reads and tests each
// stored triangle in turn, and on a hit runs the two bit-serial weight dividers.
// One request at a time; the scan rate is set by the single cross-product unit.
// Synchronous reset empties the table and drops any pending result.
module triangle_table_point_locator_top #(
  parameter int MAX_TRIANGLES = ttpl_pkg::MaxTrianglesDefault
) (
  input logic clk,
  input logic rst,
  ttpl_if.sink req,
  ttpl_if.source rsp
);
  import ttpl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ttpl_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .req_type(req.data.req_type),
    .sts, .cmd
  );

  ttpl_dp #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_dp (
    .clk, .rst, .req(req.data), .cmd, .sts, .rsp(rsp.data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken with result pending");
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.add, cmd.rd, cmd.tri_a, cmd.tri_b, cmd.tri_c}))
    else $error("conflicting datapath commands");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp.valid) else $error("result not raised");
endmodule

@@ sv/ttpl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Triangle table point locator controller
// Sequences table writes, the scan and the weight division.
// ----------------------------------------------------------------------------
module ttpl_ctrl (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input logic out_ready,
  input logic [1:0] req_type,
  input ttpl_pkg::sts_t sts,
  output ttpl_pkg::cmd_t cmd
);
  import ttpl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RD, S_TA, S_TB, S_TC, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [1:0] req_kind;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    case (state)
      S_DEC: begin
        cmd.clear = (req_kind == ReqClear);
        cmd.add = (req_kind == ReqAdd) && !sts.full;
        cmd.finish = (req_kind != ReqQuery) || sts.empty_scan;
      end
      S_RD: cmd.rd = 1'b1;
      S_TA: cmd.tri_a = 1'b1;
      S_TB: cmd.tri_b = 1'b1;
      S_TC: begin
        cmd.tri_c = 1'b1;
        cmd.div_start = sts.hit;
        cmd.finish = !sts.hit && sts.last;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.finish = sts.div_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) req_kind <= req_type;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.load) state <= S_DEC;
        S_DEC: state <= cmd.finish ? S_IDLE : S_RD;
        S_RD: state <= S_TA;
        S_TA: state <= S_TB;
        S_TB: state <= S_TC;
        S_TC: state <= sts.hit ? S_DIV : (sts.last ? S_IDLE : S_RD);
        S_DIV: if (sts.div_last) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (cmd.finish) out_valid <= 1'b1;
    end
  end
endmodule

@@ sv/ttpl_dp.sv @@
// ----------------------------------------------------------------------------
// Triangle table point locator datapath
// Triangle memory, area products, containment test and weight dividers.
// ----------------------------------------------------------------------------
module ttpl_dp #(
  parameter int MAX_TRIANGLES = ttpl_pkg::MaxTrianglesDefault
) (
  input logic clk,
  input logic rst,
  input ttpl_pkg::req_t req,
  input ttpl_pkg::cmd_t cmd,
  output ttpl_pkg::sts_t sts,
  output ttpl_pkg::rsp_t rsp
);
  import ttpl_pkg::*;

  localparam int IdxW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CntW = $clog2(MAX_TRIANGLES + 1);
  localparam int EntW = 3 * IdW + 6 * CoordW;
  localparam int DW = CoordW + 1;

  typedef logic signed [CoordW-1:0] crd_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [AreaW-1:0] area_t;

  logic [EntW-1:0] mem [MAX_TRIANGLES];
  logic [EntW-1:0] ent;
  logic [CntW-1:0] count;
  logic [CntW-1:0] scan;
  req_t r;

  logic [IdW-1:0] i0, i1, i2, t_i;
  crd_t x0, y0, x1, y1, x2, y2, t_x, t_y;

  always_comb begin
    t_i = '0; t_x = '0; t_y = '0;
    i0 = r.vertex_a_id; x0 = r.a_x; y0 = r.a_y;
    i1 = r.vertex_b_id; x1 = r.b_x; y1 = r.b_y;
    i2 = r.vertex_c_id; x2 = r.c_x; y2 = r.c_y;
    if (i0 > i1) begin
      t_i = i0; i0 = i1; i1 = t_i;
      t_x = x0; x0 = x1; x1 = t_x;
      t_y = y0; y0 = y1; y1 = t_y;
    end
    if (i1 > i2) begin
      t_i = i1; i1 = i2; i2 = t_i;
      t_x = x1; x1 = x2; x2 = t_x;
      t_y = y1; y1 = y2; y2 = t_y;
      if (i0 > i1) begin
        t_i = i0; i0 = i1; i1 = t_i;
        t_x = x0; x0 = x1; x1 = t_x;
        t_y = y0; y0 = y1; y1 = t_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (cmd.add) mem[count[IdxW-1:0]] <= {i2, i1, i0, y2, x2, y1, x1, y0, x0};
    if (cmd.rd) ent <= mem[scan[IdxW-1:0]];
  end

  crd_t ax, ay, bx, by, cx, cy, px, py;
  assign {ay, ax} = ent[0 +: 2*CoordW];
  assign {by, bx} = ent[2*CoordW +: 2*CoordW];
  assign {cy, cx} = ent[4*CoordW +: 2*CoordW];
  assign px = r.point_x;
  assign py = r.point_y;

  // One cross product per cycle: D, then Na, then Nb.
  dif_t ux, uy, vx, vy;
  always_comb begin
    if (cmd.tri_a) begin
      ux = DW'(bx) - DW'(ax); uy = DW'(by) - DW'(ay);
      vx = DW'(cx) - DW'(ax); vy = DW'(cy) - DW'(ay);
    end else if (cmd.tri_b) begin
      ux = DW'(bx) - DW'(px); uy = DW'(by) - DW'(py);
      vx = DW'(cx) - DW'(px); vy = DW'(cy) - DW'(py);
    end else begin
      ux = DW'(cx) - DW'(px); uy = DW'(cy) - DW'(py);
      vx = DW'(ax) - DW'(px); vy = DW'(ay) - DW'(py);
    end
  end
  logic signed [ProdW-1:0] p1, p2;
  assign p1 = ux * vy;
  assign p2 = uy * vx;
  area_t cr;
  assign cr = AreaW'(p1) - AreaW'(p2);

  area_t d, na, inbox_d;
  logic inbox;
  always_ff @(posedge clk) begin
    if (cmd.tri_a) begin
      d <= cr;
      inbox <= !((px < ax && px < bx && px < cx) || (px > ax && px > bx && px > cx) ||
                 (py < ay && py < by && py < cy) || (py > ay && py > by && py > cy));
    end
    if (cmd.tri_b) na <= cr;
  end
  assign inbox_d = d;

  area_t dn, nan, nbn, ncn;
  always_comb begin
    dn = inbox_d[AreaW-1] ? -inbox_d : inbox_d;
    nan = inbox_d[AreaW-1] ? -na : na;
    nbn = inbox_d[AreaW-1] ? -cr : cr;
    ncn = dn - nan - nbn;
  end

  assign sts.hit = inbox && (d != '0) && !nan[AreaW-1] && (nan <= dn) &&
                   !nbn[AreaW-1] && (nbn <= dn) && !ncn[AreaW-1] && (ncn <= dn);
  assign sts.empty_scan = (count == '0);
  assign sts.full = (count == CntW'(MAX_TRIANGLES));
  assign sts.last = (scan + 1'b1 == count);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) count <= '0;
    else if (cmd.add) count <= count + 1'b1;
    if (cmd.load) scan <= '0;
    else if (cmd.tri_c) scan <= scan + 1'b1;
  end

  // Restoring division, one quotient bit per cycle for both weights.
  logic [AreaW-1:0] dv, ra, rb;
  logic [DivSteps-1:0] qa, qb;
  logic [4:0] step;
  logic [AreaW:0] sa, sb;
  assign sa = {ra, 1'b0} - {1'b0, dv};
  assign sb = {rb, 1'b0} - {1'b0, dv};
  assign sts.div_last = (step == 5'(DivSteps));

  logic [IdW-1:0] hid0, hid1, hid2;
  logic [WeightW-1:0] wa, wb;
  logic [WeightW:0] wsum;
  logic fa, fb;
  assign fa = ({ra, 1'b0} >= {1'b0, dv});
  assign fb = ({rb, 1'b0} >= {1'b0, dv});
  always_comb begin
    wa = qa + WeightW'(fa);
    wb = qb + WeightW'(fb);
    wsum = {1'b0, wa} + {1'b0, wb};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv <= dn;
      qa <= {16'd0, (nan >= dn)};
      qb <= {16'd0, (nbn >= dn)};
      ra <= (nan >= dn) ? nan - dn : nan;
      rb <= (nbn >= dn) ? nbn - dn : nbn;
      step <= 5'd1;
      {hid2, hid1, hid0} <= ent[6*CoordW +: 3*IdW];
    end else if (cmd.div_step && !sts.div_last) begin
      ra <= sa[AreaW] ? {ra[AreaW-2:0], 1'b0} : sa[AreaW-1:0];
      rb <= sb[AreaW] ? {rb[AreaW-2:0], 1'b0} : sb[AreaW-1:0];
      qa <= {qa[DivSteps-2:0], !sa[AreaW]};
      qb <= {qb[DivSteps-2:0], !sb[AreaW]};
      step <= step + 1'b1;
    end
  end

  rsp_t rsp_next;
  always_comb begin
    rsp_next = '0;
    if (cmd.div_step) begin
      rsp_next.status = StFound;
      rsp_next.hit_a_id = hid0;
      rsp_next.hit_b_id = hid1;
      rsp_next.hit_c_id = hid2;
      rsp_next.weight_a = wa;
      rsp_next.weight_b = wb;
      rsp_next.weight_c = (wsum >= 18'h10000) ? '0 : WeightW'(18'h10000 - wsum);
    end else if (r.req_type == ReqQuery) rsp_next.status = StMiss;
    else if (r.req_type == ReqAdd && sts.full) rsp_next.status = StFull;
    else rsp_next.status = StDone;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) rsp <= rsp_next;
  end
endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Triangle table point locator testbench
// Runs a short table of directed requests, then random clear/add/query
// sequences and raw random requests with random idling on both channels, and
// checks every response against an in-bench model of the triangle table.
// ----------------------------------------------------------------------------
module testbench;
  import ttpl_pkg::*;

  localparam int MaxTri = MaxTrianglesDefault;
  localparam int RandomItems = 500;
  localparam int IdleLimit = 5000;
  localparam logic [1:0] ReqUnknown = 2'd3;

  typedef struct {
    rsp_t model;
    bit typed;
    rsp_t given;
  } expectation_t;

  typedef struct {
    req_t r;
    bit typed;
    rsp_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ttpl_if #(.T(req_t)) req_ch ();
  ttpl_if #(.T(rsp_t)) rsp_ch ();

  triangle_table_point_locator_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  logic [IdW-1:0] tri_id[MaxTri][3];
  longint tri_x[MaxTri][3];
  longint tri_y[MaxTri][3];
  int tri_count = 0;

  expectation_t pending_results[$];
  row_t directed_rows[$];
  int failures = 0;
  int sent = 0;
  int received = 0;
  int idle_cycles = 0;

  function automatic rsp_t status_only(logic [1:0] s);
    rsp_t o;
    o = '0;
    o.status = s;
    return o;
  endfunction

  function automatic logic [WeightW-1:0] weight_q16(longint n, longint d);
    logic [127:0] nn;
    logic [127:0] dd;
    logic [127:0] q;
    nn = 128'(n);
    dd = 128'(d);
    q = ((nn << 17) + dd) / (dd << 1);
    if (q > 65536) q = 65536;
    return q[WeightW-1:0];
  endfunction

  function automatic rsp_t locate_point(req_t r);
    rsp_t o;
    logic [IdW-1:0] ids[3];
    longint xs[3];
    longint ys[3];
    logic [IdW-1:0] ti;
    longint tx;
    longint ty;
    longint px;
    longint py;
    longint ax, ay, bx, by, cx, cy;
    longint d, na, nb, nc;
    logic [WeightW:0] wsum;
    o = status_only(StDone);
    case (r.req_type)
      ReqClear: begin
        tri_count = 0;
      end
      ReqAdd: begin
        if (tri_count >= MaxTri) begin
          o.status = StFull;
        end else begin
          ids[0] = r.vertex_a_id; xs[0] = r.a_x; ys[0] = r.a_y;
          ids[1] = r.vertex_b_id; xs[1] = r.b_x; ys[1] = r.b_y;
          ids[2] = r.vertex_c_id; xs[2] = r.c_x; ys[2] = r.c_y;
          for (int a = 1; a < 3; a++) begin
            for (int b = a; b > 0 && ids[b-1] > ids[b]; b--) begin
              ti = ids[b]; ids[b] = ids[b-1]; ids[b-1] = ti;
              tx = xs[b]; xs[b] = xs[b-1]; xs[b-1] = tx;
              ty = ys[b]; ys[b] = ys[b-1]; ys[b-1] = ty;
            end
          end
          for (int k = 0; k < 3; k++) begin
            tri_id[tri_count][k] = ids[k];
            tri_x[tri_count][k] = xs[k];
            tri_y[tri_count][k] = ys[k];
          end
          tri_count++;
        end
      end
      ReqQuery: begin
        o.status = StMiss;
        px = r.point_x;
        py = r.point_y;
        for (int i = 0; i < tri_count; i++) begin
          ax = tri_x[i][0]; ay = tri_y[i][0];
          bx = tri_x[i][1]; by = tri_y[i][1];
          cx = tri_x[i][2]; cy = tri_y[i][2];
          if (px < ax && px < bx && px < cx) continue;
          if (px > ax && px > bx && px > cx) continue;
          if (py < ay && py < by && py < cy) continue;
          if (py > ay && py > by && py > cy) continue;
          d = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
          if (d == 0) continue;
          na = (bx - px) * (cy - py) - (by - py) * (cx - px);
          nb = (cx - px) * (ay - py) - (cy - py) * (ax - px);
          nc = d - na - nb;
          if (d < 0) begin
            d = -d; na = -na; nb = -nb; nc = -nc;
          end
          if (na < 0 || na > d || nb < 0 || nb > d || nc < 0 || nc > d) continue;
          o.status = StFound;
          o.hit_a_id = tri_id[i][0];
          o.hit_b_id = tri_id[i][1];
          o.hit_c_id = tri_id[i][2];
          o.weight_a = weight_q16(na, d);
          o.weight_b = weight_q16(nb, d);
          wsum = o.weight_a + o.weight_b;
          o.weight_c = (wsum >= 65536) ? '0 : WeightW'(65536 - wsum);
          break;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] t, int ia, int ib, int ic, int ax, int ay,
                                    int bx, int by, int cx, int cy, int px, int py);
    req_t r;
    r.req_type = t;
    r.vertex_a_id = IdW'(ia); r.vertex_b_id = IdW'(ib); r.vertex_c_id = IdW'(ic);
    r.a_x = CoordW'(ax); r.a_y = CoordW'(ay);
    r.b_x = CoordW'(bx); r.b_y = CoordW'(by);
    r.c_x = CoordW'(cx); r.c_y = CoordW'(cy);
    r.point_x = CoordW'(px); r.point_y = CoordW'(py);
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord(int span);
    int v;
    if (span == 0) return CoordW'($urandom);
    v = $urandom_range(0, 2 * span);
    return CoordW'(v - span);
  endfunction

  function automatic req_t rand_noise();
    req_t r;
    r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom});
    return r;
  endfunction

  function automatic req_t rand_add(int span);
    req_t r;
    r = rand_noise();
    r.req_type = ReqAdd;
    if ($urandom_range(0, 3) == 0) begin
      r.vertex_b_id = r.vertex_a_id;
    end
    r.a_x = rand_coord(span); r.a_y = rand_coord(span);
    r.b_x = rand_coord(span); r.b_y = rand_coord(span);
    r.c_x = rand_coord(span); r.c_y = rand_coord(span);
    if ($urandom_range(0, 9) == 0) begin
      r.c_x = r.a_x; r.c_y = r.a_y;
    end
    return r;
  endfunction

  function automatic req_t rand_query(int span);
    req_t r;
    int i;
    int v;
    longint w0, w1, w2;
    r = rand_noise();
    r.req_type = ReqQuery;
    v = $urandom_range(0, 9);
    if (tri_count == 0 || v < 2) begin
      r.point_x = rand_coord(span);
      r.point_y = rand_coord(span);
    end else begin
      i = $urandom_range(0, tri_count - 1);
      if (v == 2) begin
        v = $urandom_range(0, 2);
        r.point_x = CoordW'(tri_x[i][v]);
        r.point_y = CoordW'(tri_y[i][v]);
      end else begin
        w0 = $urandom_range(0, 1000);
        w1 = $urandom_range(0, 1000);
        w2 = (v == 3) ? 0 : $urandom_range(0, 1000);
        if (w0 + w1 + w2 == 0) w0 = 1;
        r.point_x = CoordW'((tri_x[i][0] * w0 + tri_x[i][1] * w1 + tri_x[i][2] * w2) /
                            (w0 + w1 + w2));
        r.point_y = CoordW'((tri_y[i][0] * w0 + tri_y[i][1] * w1 + tri_y[i][2] * w2) /
                            (w0 + w1 + w2));
      end
    end
    return r;
  endfunction

  function automatic int send_gap();
    int v;
    if (sent >= 100 && sent < 160) return 0;
    v = $urandom_range(0, 99);
    if (v < 60) return 0;
    if (v < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_request(req_t r, bit typed, rsp_t given);
    int gap;
    expectation_t x;
    gap = send_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    x.model = locate_point(r);
    x.typed = typed;
    x.given = given;
    pending_results.push_back(x);
    sent++;
  endtask

  task automatic compare_rsp(string tag, rsp_t e, rsp_t g);
    if (e.status !== g.status) begin
      $error("%s status: expected %0d, got %0d", tag, e.status, g.status);
      failures++;
    end
    if (e.hit_a_id !== g.hit_a_id) begin
      $error("%s hit_a_id: expected %0d, got %0d", tag, e.hit_a_id, g.hit_a_id);
      failures++;
    end
    if (e.hit_b_id !== g.hit_b_id) begin
      $error("%s hit_b_id: expected %0d, got %0d", tag, e.hit_b_id, g.hit_b_id);
      failures++;
    end
    if (e.hit_c_id !== g.hit_c_id) begin
      $error("%s hit_c_id: expected %0d, got %0d", tag, e.hit_c_id, g.hit_c_id);
      failures++;
    end
    if (e.weight_a !== g.weight_a) begin
      $error("%s weight_a: expected %0d, got %0d", tag, e.weight_a, g.weight_a);
      failures++;
    end
    if (e.weight_b !== g.weight_b) begin
      $error("%s weight_b: expected %0d, got %0d", tag, e.weight_b, g.weight_b);
      failures++;
    end
    if (e.weight_c !== g.weight_c) begin
      $error("%s weight_c: expected %0d, got %0d", tag, e.weight_c, g.weight_c);
      failures++;
    end
  endtask

  // Response side: random stalls, one long hold-off, and a stretch of steady ready.
  initial begin
    int stall;
    bit held;
    expectation_t x;
    stall = 0;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        received++;
        if (pending_results.size() == 0) begin
          $error("response with no request waiting: status %0d", rsp_ch.data.status);
          failures++;
        end else begin
          x = pending_results.pop_front();
          compare_rsp("model", x.model, rsp_ch.data);
          if (x.typed) compare_rsp("table", x.given, rsp_ch.data);
        end
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (!held && received == 120) begin
        held = 1'b1;
        stall = 600;
        rsp_ch.ready <= 1'b0;
      end else if (received >= 200 && received < 260) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:14]: stall = $urandom_range(1, 3);
          [15:17]: stall = $urandom_range(10, 60);
          default: stall = 0;
        endcase
        rsp_ch.ready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int span;
    int n;
    bit paused;
    row_t row;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    paused = 1'b0;

    row.typed = 1'b1;
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.e = status_only(StMiss); directed_rows.push_back(row);
    row.r = make_req(ReqAdd, 9, 3, 5, 0, 0, 2560, 0, 0, 2560, 0, 0);
    row.e = status_only(StDone); directed_rows.push_back(row);
    row.typed = 1'b0;
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 256, 256);
    directed_rows.push_back(row);
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1280, 1280);
    directed_rows.push_back(row);
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3000, 3000);
    directed_rows.push_back(row);
    row.typed = 1'b1;
    row.r = make_req(ReqAdd, 1, 2, 3, 5000, 5000, 5100, 5100, 5200, 5200, 0, 0);
    row.e = status_only(StDone); directed_rows.push_back(row);
    row.typed = 1'b0;
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5100, 5100);
    directed_rows.push_back(row);
    row.typed = 1'b1;
    row.r = make_req(ReqAdd, 65535, 0, 65535, -8388608, -8388608, 8388607, -8388608,
                     -8388608, 8388607, 0, 0);
    row.e = status_only(StDone); directed_rows.push_back(row);
    row.typed = 1'b0;
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, -8388608, -8388608);
    directed_rows.push_back(row);
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8388607, 8388607);
    directed_rows.push_back(row);
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -8388608);
    directed_rows.push_back(row);
    row.r = make_req(ReqAdd, 7, 7, 7, 100, -100, -100, -100, 0, 100, 0, 0);
    directed_rows.push_back(row);
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10, -20);
    directed_rows.push_back(row);
    row.typed = 1'b1;
    row.r = make_req(ReqUnknown, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11);
    row.e = status_only(StDone); directed_rows.push_back(row);
    row.r = make_req(ReqClear, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.e = status_only(StDone); directed_rows.push_back(row);
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.e = status_only(StMiss); directed_rows.push_back(row);
    row.r = make_req(ReqAdd, 65535, 65535, 65535, 8388607, 8388607, 8388607, 8388607,
                     8388607, 8388607, 0, 0);
    row.e = status_only(StDone); directed_rows.push_back(row);
    row.typed = 1'b0;
    row.r = make_req(ReqQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8388607, 8388607);
    directed_rows.push_back(row);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].e);
    end

    while (sent < RandomItems + directed_rows.size()) begin
      if (!paused && sent >= 300) begin
        paused = 1'b1;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      span = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 4000);
      if ($urandom_range(0, 9) == 0) begin
        send_request(rand_noise(), 1'b0, '0);
      end else begin
        send_request(make_req(ReqClear, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        n = ($urandom_range(0, 7) == 0) ? MaxTri + 2 : $urandom_range(1, 8);
        repeat (n) send_request(rand_add(span), 1'b0, '0);
        n = $urandom_range(1, 8);
        repeat (n) send_request(rand_query(span), 1'b0, '0);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
